### hdl/mf3_pkg.sv
// Package for the 3x3 median filter: field widths, reset values,
// register map, result slot numbering and the per-pixel control struct.
// No dependencies.
`timescale 1ns / 1ps

package mf3_pkg;

  localparam int PIX_W          = 8;
  localparam int CFG_WIDTH_W    = 12;
  localparam int CFG_HEIGHT_W   = 13;
  localparam int APB_DATA_W     = 32;
  localparam int APB_ADDR_W     = 3;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RST  = CFG_WIDTH_W'(640);
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RST = CFG_HEIGHT_W'(480);
  localparam int                      MIN_SIZE   = 3;

  // register byte addresses
  localparam logic [APB_ADDR_W-1:0] REG_WIDTH_ADDR  = 3'd0;
  localparam logic [APB_ADDR_W-1:0] REG_HEIGHT_ADDR = 3'd4;

  // result slots one pixel can trigger, in emission order
  localparam int EMIT_N        = 4;
  localparam int SLOT_INNER    = 0;  // (r-1, c-1)
  localparam int SLOT_EDGE_COL = 1;  // (r-1, W-1) on the last column
  localparam int SLOT_EDGE_ROW = 2;  // (H-1, c-1) on the last row
  localparam int SLOT_CORNER   = 3;  // (H-1, W-1), end of frame

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic              med_ok;  // window fully interior, median is valid
    logic [EMIT_N-1:0] emit;    // one bit per result slot
  } mf3_flags_t;

endpackage

### hdl/median_filter_3x3_unit.sv
// 3x3 median filter: top level with config registers, frame counters,
// line store RAM, window/median pipeline and result sequencer.
// Depends on mf3_pkg, mf3_ram, mf3_window, mf3_emit.
// Path: a pixel is registered in stage 1, window stages s1 to s3 and the output register.
// Throughput: one pixel per clock while each pixel yields at most one result and
//   the output is not stalled; row and frame ends hold input for extra results (up to 4 per pixel).
// Reset: counters and window cleared, size 640x480; line store not cleared.
`timescale 1ns / 1ps

module median_filter_3x3_unit
  import mf3_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int COL_W     = $clog2(MAX_WIDTH),
  localparam int ROW_W     = $clog2(MAX_HEIGHT)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // pixel input
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  pix_t                  pixel_in_i,
  // result output
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output pix_t                  pixel_out_o,
  output logic [ROW_W-1:0]      out_row_o,
  output logic [COL_W-1:0]      out_col_o,
  output logic                  run_last_o,
  output logic                  frame_end_o
);

  // Widths that can hold the config value and the clamp bound together.
  localparam int WCW = ($clog2(MAX_WIDTH + 1) > CFG_WIDTH_W) ?
                       $clog2(MAX_WIDTH + 1) : CFG_WIDTH_W;
  localparam int HCW = ($clog2(MAX_HEIGHT + 1) > CFG_HEIGHT_W) ?
                       $clog2(MAX_HEIGHT + 1) : CFG_HEIGHT_W;
  localparam int RAM_W = 2 * PIX_W;  // {upper row, lower row} per column

  // ---------------------------------------------------------------------
  // Config registers. The user writes them only while the pipeline is empty (not enforced).
  // ---------------------------------------------------------------------
  logic [CFG_WIDTH_W-1:0]  width_q;
  logic [CFG_HEIGHT_W-1:0] height_q;
  logic                    cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_wr) begin
      case (paddr)
        REG_WIDTH_ADDR:  width_q  <= pwdata[CFG_WIDTH_W-1:0];
        REG_HEIGHT_ADDR: height_q <= pwdata[CFG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      REG_WIDTH_ADDR:  prdata = APB_DATA_W'(width_q);
      REG_HEIGHT_ADDR: prdata = APB_DATA_W'(height_q);
      default:         prdata = '0;
    endcase
  end

  // Effective size, clamped to [3, MAX]; kept as last index.
  logic [WCW-1:0]   w_ext, w_use;
  logic [HCW-1:0]   h_ext, h_use;
  logic [COL_W-1:0] w_m1;
  logic [ROW_W-1:0] h_m1;

  assign w_ext = WCW'(width_q);
  assign h_ext = HCW'(height_q);
  assign w_use = (w_ext < WCW'(MIN_SIZE))  ? WCW'(MIN_SIZE)  :
                 (w_ext > WCW'(MAX_WIDTH)) ? WCW'(MAX_WIDTH) : w_ext;
  assign h_use = (h_ext < HCW'(MIN_SIZE))   ? HCW'(MIN_SIZE)   :
                 (h_ext > HCW'(MAX_HEIGHT)) ? HCW'(MAX_HEIGHT) : h_ext;
  assign w_m1  = COL_W'(w_use - WCW'(1));
  assign h_m1  = ROW_W'(h_use - HCW'(1));

  // ---------------------------------------------------------------------
  // Pipeline control. Everything advances together when the output
  // sequencer can take the next record; bubbles travel like items.
  // ---------------------------------------------------------------------
  logic pipe_adv, in_acc;

  assign in_stall_o = !pipe_adv;
  assign in_acc     = in_valid_i && pipe_adv;

  // Frame position, clamped in case the size shrank mid-frame.
  logic [COL_W-1:0] col_q, col_d, c0;
  logic [ROW_W-1:0] row_q, row_d, r0;
  logic             c_last, r_last;
  mf3_flags_t       flags0;

  assign c0     = (col_q < w_m1) ? col_q : w_m1;
  assign r0     = (row_q < h_m1) ? row_q : h_m1;
  assign c_last = (c0 == w_m1);
  assign r_last = (r0 == h_m1);

  always_comb begin
    flags0.med_ok                = (r0 > ROW_W'(1)) && (c0 > COL_W'(1));
    flags0.emit                  = '0;
    flags0.emit[SLOT_INNER]      = (r0 != '0) && (c0 != '0);
    flags0.emit[SLOT_EDGE_COL]   = (r0 != '0) && c_last;
    flags0.emit[SLOT_EDGE_ROW]   = r_last && (c0 != '0);
    flags0.emit[SLOT_CORNER]     = r_last && c_last;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (c_last) begin
        col_d = '0;
        row_d = r_last ? '0 : r0 + ROW_W'(1);
      end else begin
        col_d = c0 + COL_W'(1);
        row_d = r0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: line store read issued at the transaction, data back here.
  // ---------------------------------------------------------------------
  logic             p1_vld_q;
  pix_t             p1_pix_q;
  logic [COL_W-1:0] p1_col_q;
  logic [ROW_W-1:0] p1_row_q;
  mf3_flags_t       p1_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else if (pipe_adv) begin
      p1_vld_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p1_pix_q   <= pixel_in_i;
      p1_col_q   <= c0;
      p1_row_q   <= r0;
      p1_flags_q <= flags0;
    end
  end

  // Both line stores share one RAM word per column. Column c is read when
  // its pixel arrives and written back when stage 1 advances; the next read is
  // for another column (width is at least 3), so no forwarding is needed.
  // A stalled read holds its data since no new read is issued meanwhile.
  logic             ram_re, ram_we;
  logic [COL_W-1:0] ram_raddr, ram_waddr;
  logic [RAM_W-1:0] ram_rdata, ram_wdata;
  pix_t             rd_upper, rd_lower;

  assign ram_re    = in_acc;
  assign ram_raddr = c0;
  assign ram_we    = p1_vld_q && pipe_adv;
  assign ram_waddr = p1_col_q;
  assign rd_upper  = ram_rdata[RAM_W-1:PIX_W];
  assign rd_lower  = ram_rdata[PIX_W-1:0];
  assign ram_wdata = {rd_lower, p1_pix_q};  // lower moves up, new pixel below

  mf3_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // Window and median tree.
  // ---------------------------------------------------------------------
  logic             w_vld;
  pix_t             w_med;
  mf3_flags_t       w_flags;
  logic [ROW_W-1:0] w_row;
  logic [COL_W-1:0] w_col;

  mf3_window #(
    .ROW_W (ROW_W),
    .COL_W (COL_W)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (pipe_adv),
    .vld_i   (p1_vld_q),
    .upper_i (rd_upper),
    .lower_i (rd_lower),
    .pix_i   (p1_pix_q),
    .flags_i (p1_flags_q),
    .row_i   (p1_row_q),
    .col_i   (p1_col_q),
    .vld_o   (w_vld),
    .med_o   (w_med),
    .flags_o (w_flags),
    .row_o   (w_row),
    .col_o   (w_col)
  );

  // ---------------------------------------------------------------------
  // Output register and result sequencer.
  // ---------------------------------------------------------------------
  mf3_emit #(
    .ROW_W (ROW_W),
    .COL_W (COL_W)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ld_vld_i    (w_vld),
    .ld_med_i    (w_med),
    .ld_flags_i  (w_flags),
    .ld_row_i    (w_row),
    .ld_col_i    (w_col),
    .free_o      (pipe_adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_out_o (pixel_out_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .run_last_o  (run_last_o),
    .frame_end_o (frame_end_o)
  );

  a_ram_no_collision : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("line store read and write hit the same column");

  a_p1_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p1_vld_q && !pipe_adv) |=> (p1_vld_q && $stable(p1_col_q)))
    else $error("stage 1 changed while the pipeline was held");

  a_stall_no_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_adv |-> !ram_re)
    else $error("line store read issued while held");

endmodule

### hdl/mf3_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module mf3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/mf3_window.sv
// 3x3 window held as three sorted columns plus a two-stage median tree.
// Depends on mf3_pkg.
`timescale 1ns / 1ps

module mf3_window
  import mf3_pkg::*;
#(
  parameter int ROW_W = 12,
  parameter int COL_W = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             vld_i,
  input  pix_t             upper_i,
  input  pix_t             lower_i,
  input  pix_t             pix_i,
  input  mf3_flags_t       flags_i,
  input  logic [ROW_W-1:0] row_i,
  input  logic [COL_W-1:0] col_i,
  output logic             vld_o,
  output pix_t             med_o,
  output mf3_flags_t       flags_o,
  output logic [ROW_W-1:0] row_o,
  output logic [COL_W-1:0] col_o
);

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // sorted columns, index 2 newest
  pix_t lo_q [3];
  pix_t md_q [3];
  pix_t hi_q [3];

  // stage 1: tag of the pixel whose column was just shifted in
  logic             s1_vld_q;
  mf3_flags_t       s1_flags_q;
  logic [ROW_W-1:0] s1_row_q;
  logic [COL_W-1:0] s1_col_q;

  // stage 2: row reductions of the sorted columns
  logic             s2_vld_q;
  pix_t             s2_maxlo_q, s2_medmd_q, s2_minhi_q;
  mf3_flags_t       s2_flags_q;
  logic [ROW_W-1:0] s2_row_q;
  logic [COL_W-1:0] s2_col_q;

  // stage 3: final median
  logic             s3_vld_q;
  pix_t             s3_med_q;
  mf3_flags_t       s3_flags_q;
  logic [ROW_W-1:0] s3_row_q;
  logic [COL_W-1:0] s3_col_q;

  pix_t new_lo, new_md, new_hi;

  assign new_lo = min2(min2(upper_i, lower_i), pix_i);
  assign new_md = med3(upper_i, lower_i, pix_i);
  assign new_hi = max2(max2(upper_i, lower_i), pix_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        lo_q[i] <= '0;
        md_q[i] <= '0;
        hi_q[i] <= '0;
      end
    end else if (adv_i && vld_i) begin
      lo_q[0] <= lo_q[1];
      md_q[0] <= md_q[1];
      hi_q[0] <= hi_q[1];
      lo_q[1] <= lo_q[2];
      md_q[1] <= md_q[2];
      hi_q[1] <= hi_q[2];
      lo_q[2] <= new_lo;
      md_q[2] <= new_md;
      hi_q[2] <= new_hi;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (adv_i) begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_flags_q <= flags_i;
      s1_row_q   <= row_i;
      s1_col_q   <= col_i;
      s2_maxlo_q <= max2(max2(lo_q[0], lo_q[1]), lo_q[2]);
      s2_medmd_q <= med3(md_q[0], md_q[1], md_q[2]);
      s2_minhi_q <= min2(min2(hi_q[0], hi_q[1]), hi_q[2]);
      s2_flags_q <= s1_flags_q;
      s2_row_q   <= s1_row_q;
      s2_col_q   <= s1_col_q;
      s3_med_q   <= s2_flags_q.med_ok ? med3(s2_maxlo_q, s2_medmd_q, s2_minhi_q) : '0;
      s3_flags_q <= s2_flags_q;
      s3_row_q   <= s2_row_q;
      s3_col_q   <= s2_col_q;
    end
  end

  assign vld_o   = s3_vld_q;
  assign med_o   = s3_med_q;
  assign flags_o = s3_flags_q;
  assign row_o   = s3_row_q;
  assign col_o   = s3_col_q;

endmodule

### hdl/mf3_emit.sv
// Output register and sequencer: emits up to four results per pixel.
// Depends on mf3_pkg.
`timescale 1ns / 1ps

module mf3_emit
  import mf3_pkg::*;
#(
  parameter int ROW_W = 12,
  parameter int COL_W = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             ld_vld_i,
  input  pix_t             ld_med_i,
  input  mf3_flags_t       ld_flags_i,
  input  logic [ROW_W-1:0] ld_row_i,
  input  logic [COL_W-1:0] ld_col_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pix_t             pixel_out_o,
  output logic [ROW_W-1:0] out_row_o,
  output logic [COL_W-1:0] out_col_o,
  output logic             run_last_o,
  output logic             frame_end_o
);

  logic [EMIT_N-1:0] pend_q, pend_d, pend_rem;
  pix_t              pix_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic              pop, load;

  assign out_valid_o = |pend_q;
  assign pop         = out_valid_o && !out_stall_i;
  assign pend_rem    = pend_q & (pend_q - EMIT_N'(1));  // drop lowest pending slot
  assign free_o      = !out_valid_o || (pop && (pend_rem == '0));
  assign load        = free_o && ld_vld_i;

  always_comb begin
    pend_d = pend_q;
    if (free_o) begin
      pend_d = load ? ld_flags_i.emit : '0;
    end else if (pop) begin
      pend_d = pend_rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pix_q <= ld_med_i;
      row_q <= ld_row_i;
      col_q <= ld_col_i;
    end
  end

  always_comb begin
    pixel_out_o = '0;
    out_row_o   = row_q;
    out_col_o   = col_q;
    frame_end_o = 1'b0;
    if (pend_q[SLOT_INNER]) begin
      pixel_out_o = pix_q;
      out_row_o   = row_q - ROW_W'(1);
      out_col_o   = col_q - COL_W'(1);
    end else if (pend_q[SLOT_EDGE_COL]) begin
      out_row_o   = row_q - ROW_W'(1);
    end else if (pend_q[SLOT_EDGE_ROW]) begin
      out_col_o   = col_q - COL_W'(1);
    end else begin
      frame_end_o = pend_q[SLOT_CORNER];
    end
  end

  assign run_last_o = out_valid_o && (pend_rem == '0);

  a_frame_end_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_end_o) |-> run_last_o)
    else $error("frame end not on the last result of its pixel");

  a_idle_after_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_o && !ld_vld_i) |=> !out_valid_o)
    else $error("result appeared without a loaded pixel");

  a_inner_has_coords : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && pend_q[SLOT_INNER]) |-> (row_q != '0 && col_q != '0))
    else $error("interior result with a zero coordinate");

endmodule
